// File: design/assert_macros.svh
// Assertion helpers used by the log datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CEL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check that a condition never holds outside reset
`define CEL_NEVER(lbl, clk, rst_n, cond, msg) \
    `CEL_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: design/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg
// Types and fixed constants of the circular event log.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_EMPTY   = 2'd1;
    localparam logic [1:0] STS_DONE    = 2'd2;
    localparam logic [1:0] STS_BAD_POS = 2'd3;

    localparam logic [15:0] OLDEST_MARK = 16'hFFFF;

    // One million is 2^6 * 15625: the low six bits pass straight through and
    // the rest is divided by 15625, one 16-bit digit per two steps.
    localparam logic [13:0] DIV_BASE  = 14'd15625;
    // ceil(2^44 / 15625), exact for any 30-bit partial dividend
    localparam logic [30:0] DIV_RECIP = 31'd1125899907;
    localparam int          DIV_SHIFT = 44;
    localparam int          DIV_STEPS = 8;
    localparam int          DIV_CNT_W = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_RESP
    } t_cel_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic exec;
    } t_cel_cmd;

    typedef struct packed {
        logic is_write;
        logic div_last;
    } t_cel_sts;

endpackage

// File: design/cel_in_if.sv
// ----------------------------------------------------------------------------
// cel_in_if
// Request channel of the event log: valid/ready and the request fields.
// ----------------------------------------------------------------------------
interface cel_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] event_id;
    logic [63:0] time_us;
    logic [15:0] read_position;

    modport source (output valid, action, event_id, time_us, read_position, input ready);
    modport sink (input valid, action, event_id, time_us, read_position, output ready);
endinterface

// File: design/cel_out_if.sv
// ----------------------------------------------------------------------------
// cel_out_if
// Result channel of the event log: valid/ready and the result fields.
// ----------------------------------------------------------------------------
interface cel_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] next_index;
    logic [31:0] entry_seconds;
    logic [19:0] entry_microseconds;
    logic [31:0] entry_event_id;
    logic [10:0] entry_count;

    modport source (output valid, status, next_index, entry_seconds, entry_microseconds,
                    entry_event_id, entry_count, input ready);
    modport sink (input valid, status, next_index, entry_seconds, entry_microseconds,
                  entry_event_id, entry_count, output ready);
endinterface

// File: design/cel_ctrl.sv
// ----------------------------------------------------------------------------
// cel_ctrl
// Sequencer: accepts a request, runs the divider for writes, commits the
// request to the datapath and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cel_ctrl
    import cel_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_cel_sts i_sts,
    output t_cel_cmd o_cmd
);

    t_cel_state r_state;
    t_cel_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.is_write || i_sts.div_last) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_RESP;
            ST_RESP: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.exec     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV:  o_cmd.div_step = i_sts.is_write;
            ST_EXEC: o_cmd.exec = 1'b1;
            ST_RESP: o_out_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// File: design/cel_dp.sv
// ----------------------------------------------------------------------------
// cel_dp
// Datapath: request registers, digit divider by one million, the ring
// store, the ring pointers and the result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cel_dp
    import cel_pkg::*;
#(
    parameter int LOG_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cel_cmd    i_cmd,
    output t_cel_sts    o_sts,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_event_id,
    input  logic [63:0] i_time_us,
    input  logic [15:0] i_read_position,
    output logic [1:0]  o_status,
    output logic [15:0] o_next_index,
    output logic [31:0] o_entry_seconds,
    output logic [19:0] o_entry_microseconds,
    output logic [31:0] o_entry_event_id,
    output logic [10:0] o_entry_count
);

    localparam int SW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int EW = 84;

    // Request registers
    logic [1:0]  r_action;
    logic [31:0] r_event_id;
    logic [15:0] r_pos;

    // Divider
    logic [63:0]          r_dvd;
    logic [5:0]           r_low;
    logic [13:0]          r_rem;
    logic [29:0]          r_part;
    logic [15:0]          r_qdig;
    logic [31:0]          r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [29:0]          div_part;
    logic [60:0]          div_prod;
    logic [29:0]          div_back;
    logic [29:0]          div_diff;

    // Ring pointers
    logic [SW-1:0] r_wslot;
    logic [SW-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic          r_full;

    // Store and results
    logic [EW-1:0] r_mem [LOG_DEPTH];
    logic [EW-1:0] r_rdata;
    logic          r_hit;
    logic [1:0]    r_status;
    logic [15:0]   r_next;

    logic [SW-1:0] w_next;
    logic [CW-1:0] cnt_inc;
    logic          rd_bad;
    logic          rd_lt_w;
    logic          rd_go;
    logic [SW-1:0] rd_idx;
    logic [SW-1:0] rd_after;
    logic [1:0]    n_status;
    logic [15:0]   n_next;
    logic [31:0]   cnt_wide;

    function automatic logic [SW-1:0] wrap_next(input logic [SW-1:0] slot);
        logic [SW-1:0] res;
        if (slot == SW'(LOG_DEPTH - 1)) res = '0;
        else res = slot + SW'(1);
        return res;
    endfunction

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_event_id <= i_event_id;
            r_pos      <= i_read_position;
        end
    end

    // Estimate a quotient digit by reciprocal, then take back its product
    assign div_part = {r_rem, r_dvd[63:48]};
    assign div_prod = div_part * DIV_RECIP;
    assign div_back = r_qdig * DIV_BASE;
    assign div_diff = r_part - div_back;

    // Even steps estimate the digit, odd steps keep the remainder and shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd <= {6'd0, i_time_us[63:6]};
            r_low <= i_time_us[5:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!r_div_cnt[0]) begin
                r_part <= div_part;
                r_qdig <= div_prod[DIV_SHIFT+15:DIV_SHIFT];
            end else begin
                r_rem <= div_diff[13:0];
                r_quo <= {r_quo[15:0], r_qdig};
                r_dvd <= {r_dvd[47:0], 16'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_sts.is_write = (r_action == ACT_WRITE);
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    // Decode the read
    assign w_next   = wrap_next(r_wslot);
    assign cnt_inc  = r_count + CW'(1);
    assign rd_bad   = (r_pos != OLDEST_MARK) && ({1'b0, r_pos} >= 17'(LOG_DEPTH));
    assign rd_lt_w  = ({1'b0, r_pos} < 17'(r_wslot));
    assign rd_idx   = (r_pos == OLDEST_MARK) ? r_oldest : r_pos[SW-1:0];
    assign rd_after = wrap_next(rd_idx);

    always_comb begin
        n_status = STS_OK;
        n_next   = '0;
        rd_go    = 1'b0;
        if (r_action == ACT_READ) begin
            priority if (rd_bad) begin
                n_status = STS_BAD_POS;
            end else if (r_count == '0) begin
                n_status = STS_EMPTY;
            end else if (r_pos == OLDEST_MARK || r_full || rd_lt_w) begin
                rd_go  = 1'b1;
                n_next = 16'(rd_after);
            end else begin
                n_status = STS_DONE;
                n_next   = 16'(r_wslot);
            end
        end
    end

    // Update the ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot  <= '0;
            r_oldest <= '0;
            r_count  <= '0;
            r_full   <= 1'b0;
        end else if (i_cmd.exec) begin
            if (r_action == ACT_WRITE) begin
                r_wslot <= w_next;
                if (r_full) begin
                    r_oldest <= w_next;
                end else begin
                    r_count <= cnt_inc;
                    r_full  <= (cnt_inc == CW'(LOG_DEPTH));
                end
            end else if (r_action == ACT_CLEAR) begin
                r_wslot  <= '0;
                r_oldest <= '0;
                r_count  <= '0;
                r_full   <= 1'b0;
            end
        end
    end

    // Ring store: write on commit of a write, registered read on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_action == ACT_WRITE) begin
            r_mem[r_wslot] <= {r_quo, r_rem, r_low, r_event_id};
        end
        if (i_cmd.exec) begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    // Hold the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_next   <= n_next;
            r_hit    <= rd_go;
        end
    end

    assign cnt_wide             = 32'(r_count);
    assign o_status             = r_status;
    assign o_next_index         = r_next;
    assign o_entry_seconds      = r_hit ? r_rdata[83:52] : '0;
    assign o_entry_microseconds = r_hit ? r_rdata[51:32] : '0;
    assign o_entry_event_id     = r_hit ? r_rdata[31:0] : '0;
    assign o_entry_count        = cnt_wide[10:0];

    `CEL_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(LOG_DEPTH), "count above depth")
    `CEL_ASSERT(a_full_count, i_clk, i_rst_n, r_full == (r_count == CW'(LOG_DEPTH)), "full flag and count disagree")
    `CEL_ASSERT(a_oldest_idle, i_clk, i_rst_n, !r_full |-> r_oldest == '0, "oldest slot moved before full")

endmodule

// File: design/circular_event_log_unit.sv
// ----------------------------------------------------------------------------
// circular_event_log_unit
// Overwriting ring log of timestamped events with read by position.
//
//   Channel  Dir  Handshake    Carries
//   i_req    in   valid/ready  action, event_id, time_us, read_position
//   o_rsp    out  valid/ready  status, next_index, entry fields, entry_count
//
// A write divides the timestamp by one million, one 16-bit digit at a time,
// then commits and gives its result. Read, clear and other requests skip the
// divider steps, then commit and give theirs. One request is in service at a
// time; the next is taken the cycle after the result is accepted, and a
// stalled result holds the unit. Reset is synchronous and clears pointers
// and count; store contents are undefined until written.
// ----------------------------------------------------------------------------
module circular_event_log_unit
    import cel_pkg::*;
#(
    parameter int LOG_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cel_in_if.sink    i_req,
    cel_out_if.source o_rsp
);

    t_cel_cmd cmd;
    t_cel_sts sts;

    // Sequencer
    cel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    cel_dp #(
        .LOG_DEPTH(LOG_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_action            (i_req.action),
        .i_event_id          (i_req.event_id),
        .i_time_us           (i_req.time_us),
        .i_read_position     (i_req.read_position),
        .o_status            (o_rsp.status),
        .o_next_index        (o_rsp.next_index),
        .o_entry_seconds     (o_rsp.entry_seconds),
        .o_entry_microseconds(o_rsp.entry_microseconds),
        .o_entry_event_id    (o_rsp.entry_event_id),
        .o_entry_count       (o_rsp.entry_count)
    );

endmodule
